// ===== sv/aging_fault_log_table_assert.svh =====
// Assertion macros shared by the fault log RTL.
`ifndef AGING_FAULT_LOG_TABLE_ASSERT_SVH
`define AGING_FAULT_LOG_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define AFL_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define AFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/afl_pkg.sv =====
// Types and constants shared by the fault log modules.
package afl_pkg;

  localparam int unsigned LOG_DEPTH_DEF       = 32;
  localparam int unsigned CODE_WIDTH_DEF      = 8;
  localparam int unsigned SEVERITY_LEVELS_DEF = 4;
  localparam int unsigned TIME_WIDTH_DEF      = 32;

  // Longest list a single list operation may return.
  localparam int unsigned MAX_LIST = 32;

  localparam logic [31:0] AGE_TIMEOUT_RST    = 32'd10000;
  localparam logic [1:0]  CRITICAL_LEVEL_RST = 2'd3;

  localparam logic [0:0] REG_AGE_TIMEOUT    = 1'b0;
  localparam logic [0:0] REG_CRITICAL_LEVEL = 1'b1;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_AGE    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic       status;
    logic       critical_active;
    logic [5:0] entry_count;
    logic [7:0] listed_code;
    logic       code_valid;
    logic       last;
  } res_t;

endpackage

// ===== sv/aging_fault_log_table.sv =====
// Fault log with aging: top level with configuration registers and checks.
//
// Usage: one command transaction enters on the s_axis side (tuser carries the
// opcode: report, age tick, clear or list). Every command answers with result
// transactions on the m_axis side; tlast marks the final one. Report, age tick
// and clear give exactly one result; list gives one result per active code, up
// to the clamped limit, or a single empty result.
// Timing: a command is taken only while the sequencer is idle. A rejected
// report or an empty-limit list answers at once, without scanning the entry
// store. An age tick or a clear streams all LOG_DEPTH entries out of the
// entry store, one read a cycle, behind the registered read port; a report
// streams all entries too and then passes through a write state. A list
// stops after its last result; each list result refused by a stalled
// receiver is read again from the entry store.
// The output register lets the next command enter while a result waits.
// Reset clears all active marks, the write head, the count and the critical
// flag at once, so no clearing pass is needed; stored codes, times and
// severities are only read behind an active mark. Configuration writes take
// effect at the next clock edge and must be made while the block is idle.
module aging_fault_log_table #(
  parameter int unsigned LOG_DEPTH       = afl_pkg::LOG_DEPTH_DEF,
  parameter int unsigned CODE_WIDTH      = afl_pkg::CODE_WIDTH_DEF,
  parameter int unsigned SEVERITY_LEVELS = afl_pkg::SEVERITY_LEVELS_DEF,
  parameter int unsigned TIME_WIDTH      = afl_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: fault_id [7:0], fault_severity [10:8], now_ms [42:11],
  //        list_limit [48:43], zero fill [55:49]
  input  logic [55:0] s_axis_tdata,
  // tuser: opcode [1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status [0], critical_active [1], entry_count [7:2], listed_code [15:8]
  output logic [15:0] m_axis_tdata,
  // tuser: code_valid [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned IW   = $clog2(LOG_DEPTH);
  localparam int unsigned SW   = $clog2(SEVERITY_LEVELS);
  localparam int unsigned CNTW = $clog2(LOG_DEPTH + 1);
  localparam int unsigned DW   = TIME_WIDTH + SW + CODE_WIDTH;

  logic [31:0] age_timeout_q;
  logic [1:0]  critical_level_q;

  logic          res_valid;
  logic          res_ready;
  afl_pkg::res_t res;
  logic [CNTW-1:0] eng_count;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_timeout_q    <= afl_pkg::AGE_TIMEOUT_RST;
      critical_level_q <= afl_pkg::CRITICAL_LEVEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        afl_pkg::REG_AGE_TIMEOUT:    age_timeout_q    <= cfg_wdata_i;
        afl_pkg::REG_CRITICAL_LEVEL: critical_level_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  afl_engine #(
    .LOG_DEPTH      (LOG_DEPTH),
    .CODE_WIDTH     (CODE_WIDTH),
    .SEVERITY_LEVELS(SEVERITY_LEVELS),
    .TIME_WIDTH     (TIME_WIDTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .opcode_i        (afl_pkg::op_e'(s_axis_tuser)),
    .fault_id_i      (s_axis_tdata[7:0]),
    .fault_severity_i(s_axis_tdata[10:8]),
    .now_ms_i        (s_axis_tdata[42:11]),
    .list_limit_i    (s_axis_tdata[48:43]),
    .age_timeout_i   (age_timeout_q),
    .critical_level_i(critical_level_q),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res),
    .count_o         (eng_count),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  afl_entry_ram #(
    .DEPTH(LOG_DEPTH),
    .WIDTH(DW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  afl_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_i        (res),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

`include "aging_fault_log_table_assert.svh"

  // The saturating count never goes past the log depth.
  `AFL_ASSERT(a_count_bound, eng_count <= CNTW'(LOG_DEPTH), "entry count above log depth")

  // A result is only offered while a command is in progress.
  `AFL_ASSERT(a_result_busy, !(res_valid && s_axis_tready), "result offered while idle")

  // Taking a command always makes the sequencer busy.
  `AFL_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "sequencer idle after command")

  // A result handed to the output register shows up on the stream.
  `AFL_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_axis_tvalid,
                   "handed-off result not presented")

endmodule

// ===== sv/afl_entry_ram.sv =====
// Entry store: one write port and one registered read port.
module afl_entry_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/afl_engine.sv =====
// Operation sequencer: scans the entry store, keeps active bits, head, count and flag.
module afl_engine #(
  parameter int unsigned LOG_DEPTH       = afl_pkg::LOG_DEPTH_DEF,
  parameter int unsigned CODE_WIDTH      = afl_pkg::CODE_WIDTH_DEF,
  parameter int unsigned SEVERITY_LEVELS = afl_pkg::SEVERITY_LEVELS_DEF,
  parameter int unsigned TIME_WIDTH      = afl_pkg::TIME_WIDTH_DEF,
  localparam int unsigned IW   = $clog2(LOG_DEPTH),
  localparam int unsigned SW   = $clog2(SEVERITY_LEVELS),
  localparam int unsigned CNTW = $clog2(LOG_DEPTH + 1),
  localparam int unsigned DW   = TIME_WIDTH + SW + CODE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  afl_pkg::op_e      opcode_i,
  input  logic [7:0]        fault_id_i,
  input  logic [2:0]        fault_severity_i,
  input  logic [31:0]       now_ms_i,
  input  logic [5:0]        list_limit_i,
  input  logic [31:0]       age_timeout_i,
  input  logic [1:0]        critical_level_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output afl_pkg::res_t     res_o,
  output logic [CNTW-1:0]   count_o,
  output logic              ram_we_o,
  output logic [IW-1:0]     ram_waddr_o,
  output logic [DW-1:0]     ram_wdata_o,
  output logic              ram_re_o,
  output logic [IW-1:0]     ram_raddr_o,
  input  logic [DW-1:0]     ram_rdata_i
);

  localparam int unsigned AW = IW + 1;

  afl_pkg::state_e state_q, state_d;
  afl_pkg::op_e    op_q, op_d;

  logic [CODE_WIDTH-1:0] code_q, code_d;
  logic [2:0]            sev_q, sev_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic [5:0]            lim_q, lim_d;
  logic [IW-1:0]         didx_q, didx_d;
  logic [IW-1:0]         hit_idx_q, hit_idx_d;

  logic [AW-1:0]        addr_q, addr_d;
  logic                 dv_q, dv_d;
  logic                 hit_q, hit_d;
  logic                 found_q, found_d;
  logic [5:0]           n_q, n_d;
  logic                 status_q, status_d;
  logic [LOG_DEPTH-1:0] active_q, active_d;
  logic [IW-1:0]        head_q, head_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic                 crit_q, crit_d;

  logic [15:0]           id_ext;
  logic [63:0]           now_ext;
  logic [5:0]            lim_clamp;
  logic [CODE_WIDTH-1:0] rd_code;
  logic [SW-1:0]         rd_sev;
  logic [TIME_WIDTH-1:0] rd_time;
  logic [TIME_WIDTH-1:0] age;
  logic [15:0]           rd_code_ext;
  logic                  act;
  logic                  code_hit;
  logic                  sev_crit;
  logic                  expire;
  logic                  is_end;
  logic [LOG_DEPTH-1:0]  above_mask;
  logic                  more_above;
  logic                  list_last;

  assign id_ext      = 16'(fault_id_i);
  assign now_ext     = 64'(now_ms_i);
  assign lim_clamp   = (list_limit_i > 6'(afl_pkg::MAX_LIST)) ? 6'(afl_pkg::MAX_LIST)
                                                              : list_limit_i;
  assign rd_code     = ram_rdata_i[CODE_WIDTH-1:0];
  assign rd_sev      = ram_rdata_i[CODE_WIDTH +: SW];
  assign rd_time     = ram_rdata_i[CODE_WIDTH+SW +: TIME_WIDTH];
  assign rd_code_ext = 16'(rd_code);
  assign age         = now_q - rd_time;
  assign act         = active_q[didx_q];
  assign code_hit    = act && (rd_code == code_q);
  assign sev_crit    = (3'(rd_sev) == 3'(critical_level_i));
  assign expire      = 64'(age) > 64'(age_timeout_i);
  assign is_end      = (didx_q == IW'(LOG_DEPTH - 1));
  assign above_mask  = {LOG_DEPTH{1'b1}} << (AW'(didx_q) + AW'(1));
  assign more_above  = |(active_q & above_mask);
  assign list_last   = ((n_q + 6'd1) == lim_q) || !more_above;

  assign count_o     = cnt_q;
  assign ram_wdata_o = {now_q, sev_q[SW-1:0], code_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    code_d      = code_q;
    sev_d       = sev_q;
    now_d       = now_q;
    lim_d       = lim_q;
    didx_d      = didx_q;
    hit_idx_d   = hit_idx_q;
    addr_d      = addr_q;
    dv_d        = dv_q;
    hit_d       = hit_q;
    found_d     = found_q;
    n_d         = n_q;
    status_d    = status_q;
    active_d    = active_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    crit_d      = crit_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q[IW-1:0];
    res_o.status          = status_q;
    res_o.critical_active = crit_q;
    res_o.entry_count     = 6'(cnt_q);
    res_o.listed_code     = 8'd0;
    res_o.code_valid      = 1'b0;
    res_o.last            = 1'b1;

    unique case (state_q)
      afl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d     = opcode_i;
          code_d   = id_ext[CODE_WIDTH-1:0];
          sev_d    = fault_severity_i;
          now_d    = now_ext[TIME_WIDTH-1:0];
          lim_d    = lim_clamp;
          addr_d   = '0;
          dv_d     = 1'b0;
          hit_d    = 1'b0;
          found_d  = 1'b0;
          n_d      = '0;
          status_d = 1'b0;
          state_d  = afl_pkg::ST_SCAN;
          unique case (opcode_i)
            afl_pkg::OP_REPORT: begin
              if ({1'b0, fault_severity_i} >= 4'(SEVERITY_LEVELS)) begin
                status_d = 1'b1;
                state_d  = afl_pkg::ST_RESULT;
              end
            end
            afl_pkg::OP_LIST: begin
              if (lim_clamp == 6'd0) begin
                state_d = afl_pkg::ST_RESULT;
              end
            end
            default: ;
          endcase
        end
      end

      afl_pkg::ST_SCAN: begin
        // One entry read a cycle save on a list stall; read data returns the next cycle.
        dv_d   = 1'b0;
        didx_d = addr_q[IW-1:0];
        if (addr_q < AW'(LOG_DEPTH)) begin
          ram_re_o = 1'b1;
          addr_d   = addr_q + AW'(1);
          dv_d     = 1'b1;
        end
        if (dv_q) begin
          unique case (op_q)
            afl_pkg::OP_REPORT: begin
              if (code_hit && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = didx_q;
              end
              if (is_end) begin
                state_d = afl_pkg::ST_WRITE;
              end
            end
            afl_pkg::OP_AGE: begin
              if (act) begin
                if (expire) begin
                  active_d[didx_q] = 1'b0;
                  if (cnt_q != '0) begin
                    cnt_d = cnt_q - CNTW'(1);
                  end
                end else if (sev_crit) begin
                  found_d = 1'b1;
                end
              end
              if (is_end) begin
                crit_d   = found_d;
                status_d = 1'b0;
                state_d  = afl_pkg::ST_RESULT;
              end
            end
            afl_pkg::OP_CLEAR: begin
              // The flag rescan skips only the entry being cleared.
              if (code_hit && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = didx_q;
              end else if (act && sev_crit) begin
                found_d = 1'b1;
              end
              if (is_end) begin
                state_d = afl_pkg::ST_RESULT;
                if (hit_d) begin
                  active_d[hit_idx_d] = 1'b0;
                  if (cnt_q != '0) begin
                    cnt_d = cnt_q - CNTW'(1);
                  end
                  crit_d   = found_d;
                  status_d = 1'b0;
                end else begin
                  status_d = 1'b1;
                end
              end
            end
            afl_pkg::OP_LIST: begin
              if (act) begin
                res_valid_o       = 1'b1;
                res_o.status      = 1'b0;
                res_o.listed_code = rd_code_ext[7:0];
                res_o.code_valid  = 1'b1;
                res_o.last        = list_last;
                if (res_ready_i) begin
                  n_d = n_q + 6'd1;
                  if (list_last) begin
                    dv_d    = 1'b0;
                    state_d = afl_pkg::ST_IDLE;
                  end
                end else begin
                  // Receiver stalled: read the same entry again.
                  addr_d = AW'(didx_q);
                  dv_d   = 1'b0;
                end
              end else if (is_end) begin
                status_d = 1'b0;
                state_d  = (n_q == 6'd0) ? afl_pkg::ST_RESULT : afl_pkg::ST_IDLE;
              end
            end
            default: ;
          endcase
        end
      end

      afl_pkg::ST_WRITE: begin
        ram_we_o = 1'b1;
        if (hit_q) begin
          ram_waddr_o = hit_idx_q;
        end else begin
          active_d[head_q] = 1'b1;
          head_d = (head_q == IW'(LOG_DEPTH - 1)) ? '0 : head_q + IW'(1);
          if (cnt_q != CNTW'(LOG_DEPTH)) begin
            cnt_d = cnt_q + CNTW'(1);
          end
        end
        if (sev_q == 3'(critical_level_i)) begin
          crit_d = 1'b1;
        end
        status_d = 1'b0;
        state_d  = afl_pkg::ST_RESULT;
      end

      afl_pkg::ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = afl_pkg::ST_IDLE;
        end
      end

      default: state_d = afl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= afl_pkg::ST_IDLE;
      op_q     <= afl_pkg::OP_REPORT;
      addr_q   <= '0;
      dv_q     <= 1'b0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      n_q      <= '0;
      status_q <= 1'b0;
      active_q <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
      crit_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      dv_q     <= dv_d;
      hit_q    <= hit_d;
      found_q  <= found_d;
      n_q      <= n_d;
      status_q <= status_d;
      active_q <= active_d;
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      crit_q   <= crit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    sev_q     <= sev_d;
    now_q     <= now_d;
    lim_q     <= lim_d;
    didx_q    <= didx_d;
    hit_idx_q <= hit_idx_d;
  end

endmodule

// ===== sv/afl_out_stage.sv =====
// Output register between the sequencer and the result stream.
module afl_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  afl_pkg::res_t res_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata,
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  logic          valid_q, valid_d;
  afl_pkg::res_t data_q;

  assign res_ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {data_q.listed_code, data_q.entry_count,
                          data_q.critical_active, data_q.status};
  assign m_axis_tuser  = data_q.code_valid;
  assign m_axis_tlast  = data_q.last;

endmodule
